/* hdl/vss_pkg.sv */
package vss_pkg;

  // Set size limit and sample format.
  localparam int MAX_COUNT   = 65536;
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_W     = $clog2(MAX_COUNT + 1);

  // Accumulator widths.
  localparam int SUM_W   = 33;
  localparam int SUMSQ_W = 47;

  // Result widths.
  localparam int MEAN_W = 24;
  localparam int NORM_W = 31;
  localparam int RMS_W  = 24;

  // Shared compare-subtract unit and its iteration counts.
  localparam int OPND_W     = 64;
  localparam int REM_W      = 34;
  localparam int STEP_W     = 36;
  localparam int ROOT_W     = 32;
  localparam int SQRT_STEPS = OPND_W / 2;
  localparam int DIV_STEPS  = OPND_W;
  localparam int STEPS_W    = $clog2(DIV_STEPS);

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic signed [SAMPLE_BITS-1:0] maximum;
    logic signed [MEAN_W-1:0]      mean;
    logic [NORM_W-1:0]             norm;
    logic [RMS_W-1:0]              root_mean_square;
    logic [COUNT_W-1:0]            sample_count;
    logic                          overflow;
  } out_word_t;

  // Running totals of one set.
  typedef struct packed {
    logic [COUNT_W-1:0]            count;
    logic signed [SAMPLE_BITS-1:0] minimum;
    logic signed [SAMPLE_BITS-1:0] maximum;
    logic signed [SUM_W-1:0]       sum;
    logic [SUMSQ_W-1:0]            sumsq;
    logic                          dropped;
  } set_t;

endpackage

/* hdl/vss_in_if.sv */
interface vss_in_if;
  logic              valid;
  logic              ready;
  vss_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/vss_out_if.sv */
interface vss_out_if;
  logic               valid;
  logic               ready;
  vss_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/vss_accum.sv */
module vss_accum (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   accept,
  input  logic signed [vss_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   last,
  output vss_pkg::set_t                          upd
);
  import vss_pkg::*;

  set_t                     cur;
  logic signed [2*SAMPLE_BITS-1:0] sq;

  // Square of the incoming sample; never negative.
  assign sq = sample * sample;

  // Totals with the incoming word folded in.
  always_comb begin
    upd = cur;
    if (cur.count >= COUNT_W'(MAX_COUNT)) begin
      upd.dropped = 1'b1;
    end else begin
      if (cur.count == '0) begin
        upd.minimum = sample;
        upd.maximum = sample;
      end else begin
        if (sample < cur.minimum) upd.minimum = sample;
        if (sample > cur.maximum) upd.maximum = sample;
      end
      upd.sum   = cur.sum + SUM_W'(sample);
      upd.sumsq = cur.sumsq + SUMSQ_W'($unsigned(sq));
      upd.count = cur.count + COUNT_W'(1);
    end
  end

  // Totals advance on each accepted word and clear once the final word of a set
  // is taken. Minimum and maximum are only read after the first word has loaded
  // them, so they have no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur.count   <= '0;
      cur.sum     <= '0;
      cur.sumsq   <= '0;
      cur.dropped <= 1'b0;
    end else if (accept) begin
      cur.minimum <= upd.minimum;
      cur.maximum <= upd.maximum;
      if (last) begin
        cur.count   <= '0;
        cur.sum     <= '0;
        cur.sumsq   <= '0;
        cur.dropped <= 1'b0;
      end else begin
        cur.count   <= upd.count;
        cur.sum     <= upd.sum;
        cur.sumsq   <= upd.sumsq;
        cur.dropped <= upd.dropped;
      end
    end
  end

endmodule

/* hdl/vss_step.sv */
module vss_step (
  input  logic [vss_pkg::STEP_W-1:0] partial,
  input  logic [vss_pkg::STEP_W-1:0] trial,
  output logic                       ge,
  output logic [vss_pkg::STEP_W-1:0] diff
);
  import vss_pkg::*;

  logic [STEP_W:0] wide;

  // One restoring step: compare and subtract share a single adder.
  assign wide = {1'b0, partial} - {1'b0, trial};
  assign ge   = ~wide[STEP_W];
  assign diff = wide[STEP_W-1:0];

endmodule

/* hdl/vss_seq.sv */
module vss_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  vss_pkg::set_t upd,
  output logic          idle,
  vss_out_if.source     stats
);
  import vss_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_NORM = 3'd1;
  localparam logic [2:0] ST_DIVQ = 3'd2;
  localparam logic [2:0] ST_RMS  = 3'd3;
  localparam logic [2:0] ST_MEAN = 3'd4;
  localparam logic [2:0] ST_HOLD = 3'd5;

  logic [2:0]            state;
  logic [STEPS_W-1:0]    steps;
  logic [OPND_W-1:0]     opnd;
  logic [REM_W-1:0]      rem;
  logic [OPND_W-1:0]     res;
  logic [OPND_W-2:0]     scaled_sq;
  logic [COUNT_W-1:0]    divisor;
  logic                  sum_neg;
  logic [SUM_W-2:0]      sum_mag;
  logic [SUM_W-1:0]      sum_abs;
  out_word_t             result;

  logic                  is_root;
  logic                  last_step;
  logic [STEP_W-1:0]     partial;
  logic [STEP_W-1:0]     trial;
  logic                  ge;
  logic [STEP_W-1:0]     diff;
  logic [REM_W-1:0]      rem_next;
  logic [OPND_W-1:0]     res_next;
  logic [MEAN_W-1:0]     mean_mag;

  assign idle    = (state == ST_IDLE);
  assign is_root = (state == ST_NORM) || (state == ST_RMS);

  // Magnitude of the incoming sum; it always fits one bit narrower.
  assign sum_abs = upd.sum[SUM_W-1] ? -upd.sum : upd.sum;

  // Last iteration of the current phase.
  always_comb begin
    if (is_root) last_step = (steps == STEPS_W'(SQRT_STEPS - 1));
    else         last_step = (steps == STEPS_W'(DIV_STEPS - 1));
  end

  // Operands of the shared unit: root digit pair or quotient bit.
  always_comb begin
    if (is_root) begin
      partial = {rem, opnd[OPND_W-1 -: 2]};
      trial   = STEP_W'({res[ROOT_W-1:0], 2'b01});
    end else begin
      partial = STEP_W'({rem, opnd[OPND_W-1]});
      trial   = STEP_W'(divisor);
    end
  end

  vss_step u_step (
    .partial (partial),
    .trial   (trial),
    .ge      (ge),
    .diff    (diff)
  );

  assign rem_next = ge ? diff[REM_W-1:0] : partial[REM_W-1:0];
  assign res_next = {res[OPND_W-2:0], ge};
  assign mean_mag = res_next[MEAN_W-1:0];

  // Sequencer: norm root, mean-square divide, its root, then the mean divide.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      steps <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (load) begin
            state <= ST_NORM;
            steps <= '0;
          end
        end
        ST_NORM, ST_DIVQ, ST_RMS: begin
          steps <= steps + STEPS_W'(1);
          if (last_step) begin
            state <= state + 3'd1;
            steps <= '0;
          end
        end
        ST_MEAN: begin
          steps <= steps + STEPS_W'(1);
          if (last_step) begin
            state <= ST_HOLD;
            steps <= '0;
          end
        end
        ST_HOLD: begin
          if (!stats.valid || stats.ready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath of the shared unit and the partial results.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (load) begin
          scaled_sq             <= {upd.sumsq, 16'b0};
          opnd                  <= {1'b0, upd.sumsq, 16'b0};
          rem                   <= '0;
          res                   <= '0;
          divisor               <= upd.count;
          sum_neg               <= upd.sum[SUM_W-1];
          sum_mag               <= sum_abs[SUM_W-2:0];
          result.minimum        <= upd.minimum;
          result.maximum        <= upd.maximum;
          result.sample_count   <= upd.count;
          result.overflow       <= upd.dropped;
        end
      end
      ST_NORM: begin
        rem  <= rem_next;
        res  <= res_next;
        opnd <= {opnd[OPND_W-3:0], 2'b00};
        if (last_step) begin
          // Only an all most-negative full set reaches 2^31; it saturates.
          result.norm <= res_next[ROOT_W-1] ? {NORM_W{1'b1}} : res_next[NORM_W-1:0];
          opnd        <= {1'b0, scaled_sq};
          rem         <= '0;
          res         <= '0;
        end
      end
      ST_DIVQ: begin
        rem  <= rem_next;
        res  <= res_next;
        opnd <= {opnd[OPND_W-2:0], 1'b0};
        if (last_step) begin
          opnd <= res_next;
          rem  <= '0;
          res  <= '0;
        end
      end
      ST_RMS: begin
        rem  <= rem_next;
        res  <= res_next;
        opnd <= {opnd[OPND_W-3:0], 2'b00};
        if (last_step) begin
          result.root_mean_square <= res_next[RMS_W-1:0];
          opnd <= {(OPND_W - SUM_W - 7)'(0), sum_mag, 8'b0};
          rem  <= '0;
          res  <= '0;
        end
      end
      ST_MEAN: begin
        rem  <= rem_next;
        res  <= res_next;
        opnd <= {opnd[OPND_W-2:0], 1'b0};
        if (last_step) begin
          result.mean <= sum_neg ? -mean_mag : mean_mag;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register; a finished result waits here until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      stats.valid <= 1'b0;
    end else if (state == ST_HOLD && (!stats.valid || stats.ready)) begin
      stats.valid <= 1'b1;
    end else if (stats.ready) begin
      stats.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && (!stats.valid || stats.ready)) begin
      stats.data <= result;
    end
  end

endmodule

/* hdl/vector_summary_statistics.sv */
// Summary statistics of a streamed set of signed 16-bit samples. Each word on
// the input carries one sample, and the word flagged as last closes the set.
// Samples that are not last are taken one per cycle while no set is being
// finished and folded into a count, running minimum and maximum, a sum and a
// sum of squares. The last sample starts a sequencer that drives one shared
// compare-subtract unit: a 32-step square root for the norm, a 64-step divide
// of the scaled sum of squares by the count, a 32-step root of that for the
// RMS and a 64-step divide for the mean. Input ready is low from a last sample
// until its result enters the output register, which waits for the previous
// result to be taken. Mean, norm and RMS carry 8 fraction bits; the mean
// truncates toward zero, the roots are floored and the norm saturates at 2^31 - 1.
// Samples beyond 65536 in one set are dropped and the set's result flags overflow.
module vector_summary_statistics (
  input  logic      clk,
  input  logic      rst,
  vss_in_if.sink    samples,
  vss_out_if.source stats
);
  import vss_pkg::*;

  logic accept;
  logic load;
  logic idle;
  set_t upd;

  // New words are taken whenever no set is being finished.
  assign samples.ready = idle;
  assign accept        = samples.valid && samples.ready;
  assign load          = accept && samples.data.last;

  vss_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sample (samples.data.sample),
    .last   (samples.data.last),
    .upd    (upd)
  );

  vss_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .load  (load),
    .upd   (upd),
    .idle  (idle),
    .stats (stats)
  );

endmodule
